// ----- design/fdpq_pkg.sv -----
package fdpq_pkg;

  localparam int CMD_W     = 2;
  localparam int PID_W     = 7;
  localparam int PRIO_W    = 2;
  localparam int TIME_W    = 32;
  localparam int QUANT_W   = 16;
  localparam int MAX_PROCS = 128;
  localparam int PTR_W     = $clog2(MAX_PROCS);
  localparam int CNT_W     = $clog2(MAX_PROCS + 1);

  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  localparam logic [CMD_W-1:0] CMD_READY   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LEAVE   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_PREEMPT = 2'd2;

  localparam logic [PRIO_W-1:0] PRIO_HIGH = 2'd0;
  localparam logic [PRIO_W-1:0] PRIO_MID  = 2'd1;

  localparam logic [1:0] REG_Q_HIGH = 2'd0;
  localparam logic [1:0] REG_Q_MID  = 2'd1;
  localparam logic [1:0] REG_Q_LOW  = 2'd2;

  localparam logic [QUANT_W-1:0] Q_HIGH_RST = 16'd10;
  localparam logic [QUANT_W-1:0] Q_MID_RST  = 16'd5;
  localparam logic [QUANT_W-1:0] Q_LOW_RST  = 16'd2;

  // queue actions for the cycle, taken only when the pipeline advances
  typedef struct packed {
    logic push;
    logic pop;
  } ring_ctl_t;

  typedef struct packed {
    logic empty;
    logic full;
  } ring_stat_t;

endpackage

// ----- design/fdpq_ifs.sv -----
interface fdpq_in_if;
  logic                        valid;
  logic                        ready;
  logic [fdpq_pkg::CMD_W-1:0]  cmd;
  logic [fdpq_pkg::PID_W-1:0]  proc_id;
  logic [fdpq_pkg::PRIO_W-1:0] proc_priority;
  logic [fdpq_pkg::TIME_W-1:0] now;

  modport source (output valid, cmd, proc_id, proc_priority, now, input ready);
  modport sink (input valid, cmd, proc_id, proc_priority, now, output ready);
endinterface

interface fdpq_out_if;
  logic                        valid;
  logic                        ready;
  logic                        dispatched;
  logic                        cpu_busy;
  logic [fdpq_pkg::PID_W-1:0]  running_id;
  logic [fdpq_pkg::TIME_W-1:0] slice_end;
  logic                        enqueue_dropped;

  modport source (output valid, dispatched, cpu_busy, running_id, slice_end,
                  enqueue_dropped, input ready);
  modport sink (input valid, dispatched, cpu_busy, running_id, slice_end,
                enqueue_dropped, output ready);
endinterface

// ----- design/fdpq_ring.sv -----
module fdpq_ring (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       adv,
  input  fdpq_pkg::ring_ctl_t        ctl,
  input  logic [fdpq_pkg::PID_W-1:0] wr_id,
  output fdpq_pkg::ring_stat_t       stat,
  output logic [fdpq_pkg::PID_W-1:0] head_id
);

  logic [fdpq_pkg::PID_W-1:0] mem [fdpq_pkg::MAX_PROCS];
  logic [fdpq_pkg::PTR_W-1:0] head_r, head_nxt;
  logic [fdpq_pkg::PTR_W-1:0] tail_r, tail_nxt;
  logic [fdpq_pkg::CNT_W-1:0] count_r, count_nxt;
  logic [fdpq_pkg::PID_W-1:0] rd_r;

  localparam logic [fdpq_pkg::PTR_W-1:0] LAST = fdpq_pkg::PTR_W'(fdpq_pkg::MAX_PROCS - 1);

  assign stat.empty = (count_r == '0);
  assign stat.full  = (count_r == fdpq_pkg::CNT_W'(fdpq_pkg::MAX_PROCS));
  assign head_id    = rd_r;

  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    if (ctl.pop) begin
      head_nxt = (head_r == LAST) ? '0 : head_r + 1'b1;
    end
    if (ctl.push) begin
      tail_nxt = (tail_r == LAST) ? '0 : tail_r + 1'b1;
    end
    count_nxt = count_r + fdpq_pkg::CNT_W'(ctl.push) - fdpq_pkg::CNT_W'(ctl.pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else if (adv) begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

  // read returns the old slot contents; an empty-queue push is bypassed upstream
  always_ff @(posedge clk) begin
    if (adv) begin
      rd_r <= mem[head_r];
      if (ctl.push) begin
        mem[tail_r] <= wr_id;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= fdpq_pkg::CNT_W'(fdpq_pkg::MAX_PROCS))
    else $error("ring count above depth");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    adv && ctl.pop |-> !stat.empty || ctl.push)
    else $error("pop from empty ring");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    adv && ctl.push |-> !stat.full)
    else $error("push into full ring");

endmodule

// ----- design/fifo_dispatcher_with_priority_quantum.sv -----
// Single-CPU dispatcher with a FIFO ready queue and priority-based time slice.
// in_ch carries one event item (cmd, proc_id, proc_priority, now); out_ch returns
// exactly one result item per event, in order. Both use valid/ready.
// APB port: quantum_high at 0x0, quantum_mid at 0x4, quantum_low at 0x8; write
// only while no item is in flight. Reads return the register value.
// Pipeline: input register, queue update, id lookup into the priority table,
// then slice add into the output register. Throughput is one item per cycle
// while out_ch does not stall; the queue pointers, the ring memory read of the
// head slot and the priority table read each take one stage.
// When out_ch stalls (valid high, ready low), every stage holds and in_ch.ready
// drops until the result is taken.
// Synchronous reset (rst_n low): queue empty, CPU idle, no item in flight,
// quanta back to 10, 5 and 2. Ring and priority table contents are not cleared.
module fifo_dispatcher_with_priority_quantum (
  input  logic                            clk,
  input  logic                            rst_n,
  fdpq_in_if.sink                         in_ch,
  fdpq_out_if.source                      out_ch,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [fdpq_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [fdpq_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [fdpq_pkg::CFG_DATA_W-1:0] prdata,
  output logic                            pready
);

  typedef struct packed {
    logic [fdpq_pkg::CMD_W-1:0]  cmd;
    logic [fdpq_pkg::PID_W-1:0]  pid;
    logic [fdpq_pkg::PRIO_W-1:0] prio;
    logic [fdpq_pkg::TIME_W-1:0] now;
  } item_t;

  typedef struct packed {
    logic                        disp;
    logic                        do_disp;
    logic                        bypass;
    logic                        dropped;
    logic [fdpq_pkg::PID_W-1:0]  pid;
    logic [fdpq_pkg::TIME_W-1:0] now;
  } s2_t;

  typedef struct packed {
    logic                        disp;
    logic                        do_disp;
    logic                        dropped;
    logic [fdpq_pkg::PID_W-1:0]  id;
    logic [fdpq_pkg::TIME_W-1:0] now;
  } s3_t;

  typedef struct packed {
    logic                        dispatched;
    logic                        cpu_busy;
    logic [fdpq_pkg::PID_W-1:0]  running_id;
    logic [fdpq_pkg::TIME_W-1:0] slice_end;
    logic                        enqueue_dropped;
  } res_t;

  logic [fdpq_pkg::QUANT_W-1:0] q_high_r, q_mid_r, q_low_r;
  logic                         cfg_wr;

  logic                         adv;
  logic                         v1_r, v2_r, v3_r, out_valid_r;
  item_t                        in_r;
  s2_t                          s2_r, s2_nxt;
  s3_t                          s3_r, s3_nxt;
  res_t                         out_r, res_nxt;

  logic                         busy1_r, busy1_nxt;
  logic                         is_ready, is_preempt, push_req, push_ok, do_disp, pop;
  fdpq_pkg::ring_ctl_t          ring_ctl;
  fdpq_pkg::ring_stat_t         ring_stat;
  logic [fdpq_pkg::PID_W-1:0]   ring_head_id;

  logic [fdpq_pkg::PRIO_W-1:0]  prio_tbl [fdpq_pkg::MAX_PROCS];
  logic [fdpq_pkg::PRIO_W-1:0]  prio3_r;

  logic                         cur_valid_r;
  logic [fdpq_pkg::PID_W-1:0]   cur_id_r;
  logic [fdpq_pkg::TIME_W-1:0]  cur_time_r;
  logic [fdpq_pkg::QUANT_W-1:0] quantum;
  logic [fdpq_pkg::TIME_W-1:0]  due;

  // ---- configuration ----
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_high_r <= fdpq_pkg::Q_HIGH_RST;
      q_mid_r  <= fdpq_pkg::Q_MID_RST;
      q_low_r  <= fdpq_pkg::Q_LOW_RST;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        fdpq_pkg::REG_Q_HIGH: q_high_r <= pwdata[fdpq_pkg::QUANT_W-1:0];
        fdpq_pkg::REG_Q_MID:  q_mid_r  <= pwdata[fdpq_pkg::QUANT_W-1:0];
        fdpq_pkg::REG_Q_LOW:  q_low_r  <= pwdata[fdpq_pkg::QUANT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      fdpq_pkg::REG_Q_HIGH: prdata = fdpq_pkg::CFG_DATA_W'(q_high_r);
      fdpq_pkg::REG_Q_MID:  prdata = fdpq_pkg::CFG_DATA_W'(q_mid_r);
      fdpq_pkg::REG_Q_LOW:  prdata = fdpq_pkg::CFG_DATA_W'(q_low_r);
      default:              prdata = '0;
    endcase
  end

  // ---- pipeline control: every stage moves together ----
  assign adv         = !out_valid_r || out_ch.ready;
  assign in_ch.ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      v1_r        <= in_ch.valid;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      out_valid_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      in_r.cmd  <= in_ch.cmd;
      in_r.pid  <= in_ch.proc_id;
      in_r.prio <= in_ch.proc_priority;
      in_r.now  <= in_ch.now;
      s2_r      <= s2_nxt;
      s3_r      <= s3_nxt;
      out_r     <= res_nxt;
    end
  end

  // ---- stage 1: queue decisions ----
  always_comb begin
    is_ready   = v1_r && (in_r.cmd == fdpq_pkg::CMD_READY);
    is_preempt = v1_r && (in_r.cmd == fdpq_pkg::CMD_PREEMPT);
    push_req   = is_ready || is_preempt;
    push_ok    = push_req && !ring_stat.full;
    // a ready event with the CPU busy only queues
    do_disp    = v1_r && !(is_ready && busy1_r);
    pop        = do_disp && (!ring_stat.empty || push_ok);
    busy1_nxt  = do_disp ? pop : busy1_r;

    ring_ctl.push = push_ok;
    ring_ctl.pop  = pop;

    s2_nxt.disp    = pop;
    s2_nxt.do_disp = do_disp;
    s2_nxt.bypass  = ring_stat.empty;
    s2_nxt.dropped = push_req && ring_stat.full;
    s2_nxt.pid     = in_r.pid;
    s2_nxt.now     = in_r.now;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy1_r <= 1'b0;
    end else if (adv) begin
      busy1_r <= busy1_nxt;
    end
  end

  fdpq_ring u_ring (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .ctl     (ring_ctl),
    .wr_id   (in_r.pid),
    .stat    (ring_stat),
    .head_id (ring_head_id)
  );

  // ---- stage 2: dispatched id, priority lookup ----
  always_comb begin
    s3_nxt.disp    = s2_r.disp;
    s3_nxt.do_disp = s2_r.do_disp;
    s3_nxt.dropped = s2_r.dropped;
    // queue was empty: the only thing to pop is the item pushed this event
    s3_nxt.id      = s2_r.bypass ? s2_r.pid : ring_head_id;
    s3_nxt.now     = s2_r.now;
  end

  // read sees writes of this item and earlier ones; this edge's write belongs to a later one
  always_ff @(posedge clk) begin
    if (adv) begin
      prio3_r <= prio_tbl[s3_nxt.id[fdpq_pkg::PTR_W-1:0]];
      if (is_ready) begin
        prio_tbl[in_r.pid[fdpq_pkg::PTR_W-1:0]] <= in_r.prio;
      end
    end
  end

  // ---- stage 3: slice add, running state ----
  always_comb begin
    unique case (prio3_r)
      fdpq_pkg::PRIO_HIGH: quantum = q_high_r;
      fdpq_pkg::PRIO_MID:  quantum = q_mid_r;
      default:             quantum = q_low_r;
    endcase
    due = s3_r.now + fdpq_pkg::TIME_W'(quantum);

    res_nxt.enqueue_dropped = s3_r.dropped;
    if (!s3_r.do_disp) begin
      res_nxt.dispatched = 1'b0;
      res_nxt.cpu_busy   = cur_valid_r;
      res_nxt.running_id = cur_id_r;
      res_nxt.slice_end  = cur_time_r;
    end else if (s3_r.disp) begin
      res_nxt.dispatched = 1'b1;
      res_nxt.cpu_busy   = 1'b1;
      res_nxt.running_id = s3_r.id;
      res_nxt.slice_end  = due;
    end else begin
      res_nxt.dispatched = 1'b0;
      res_nxt.cpu_busy   = 1'b0;
      res_nxt.running_id = '0;
      res_nxt.slice_end  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      cur_id_r    <= '0;
      cur_time_r  <= '0;
    end else if (adv && v3_r && s3_r.do_disp) begin
      cur_valid_r <= res_nxt.cpu_busy;
      cur_id_r    <= res_nxt.running_id;
      cur_time_r  <= res_nxt.slice_end;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.dispatched      = out_r.dispatched;
  assign out_ch.cpu_busy        = out_r.cpu_busy;
  assign out_ch.running_id      = out_r.running_id;
  assign out_ch.slice_end       = out_r.slice_end;
  assign out_ch.enqueue_dropped = out_r.enqueue_dropped;

  a_disp_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.dispatched |-> out_r.cpu_busy)
    else $error("dispatch reported with idle cpu");

  a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_r.cpu_busy |-> out_r.running_id == '0 && out_r.slice_end == '0)
    else $error("idle result carries a process");

  a_busy_track: assert property (@(posedge clk) disable iff (!rst_n)
    !v2_r && !v3_r |-> busy1_r == cur_valid_r)
    else $error("front and back busy flags disagree with pipeline empty");

  a_drop_push: assert property (@(posedge clk) disable iff (!rst_n)
    adv && v1_r && s2_nxt.dropped |-> is_ready || is_preempt)
    else $error("drop flagged without an enqueue");

endmodule

// ----- sim/tb_fifo_dispatcher_with_priority_quantum.sv -----
`timescale 1ns / 100ps

module tb_fifo_dispatcher_with_priority_quantum;
  import fdpq_pkg::*;

  localparam logic [CMD_W-1:0]  CMD_LEAVE_ALT = 2'd3;  // undefined code, behaves as leave
  localparam logic [PRIO_W-1:0] PRIO_LOW      = 2'd2;
  localparam logic [PRIO_W-1:0] PRIO_SPARE    = 2'd3;  // undefined level, gets the low slice
  localparam int                DRAIN_CYCLES  = 8;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [PID_W-1:0]  proc_id;
    logic [PRIO_W-1:0] proc_priority;
    logic [TIME_W-1:0] now;
  } sched_event_t;

  typedef struct packed {
    logic              dispatched;
    logic              cpu_busy;
    logic [PID_W-1:0]  running_id;
    logic [TIME_W-1:0] slice_end;
    logic              enqueue_dropped;
  } sched_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  fdpq_in_if  in_ch ();
  fdpq_out_if out_ch ();

  fifo_dispatcher_with_priority_quantum DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // dispatcher mirror
  logic [PID_W-1:0]  ring_mem [MAX_PROCS];
  logic [PTR_W-1:0]  ring_rd;
  logic [PTR_W-1:0]  ring_wr;
  logic [CNT_W-1:0]  ring_cnt;
  logic [PRIO_W-1:0] prio_tab [MAX_PROCS];
  logic              prio_known [MAX_PROCS];
  logic [PID_W-1:0]  cpu_id;
  logic              cpu_valid;
  logic [TIME_W-1:0] cpu_deadline;
  logic [QUANT_W-1:0] q_high;
  logic [QUANT_W-1:0] q_mid;
  logic [QUANT_W-1:0] q_low;

  sched_result_t expected_q [$];
  sched_result_t want_res;
  int            errors;
  logic          tx_gaps_on;
  logic          rx_stalls_on;
  int            stall_left;
  logic [TIME_W-1:0] sim_now;

  function automatic int gap_cycles();
    return ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
  endfunction

  function automatic logic ring_push(input logic [PID_W-1:0] pid);
    if (ring_cnt >= MAX_PROCS) return 1'b0;
    ring_mem[ring_wr] = pid;
    ring_wr++;
    ring_cnt++;
    return 1'b1;
  endfunction

  function automatic sched_result_t predict_dispatch(input sched_event_t ev);
    sched_result_t      r;
    logic               do_disp;
    logic [PRIO_W-1:0]  p;
    logic [QUANT_W-1:0] q;
    r = '0;
    do_disp = 1'b1;
    if (ev.cmd == CMD_READY) begin
      prio_tab[ev.proc_id] = ev.proc_priority;
      prio_known[ev.proc_id] = 1'b1;
      r.enqueue_dropped = !ring_push(ev.proc_id);
      if (cpu_valid) do_disp = 1'b0;
    end else if (ev.cmd == CMD_PREEMPT) begin
      r.enqueue_dropped = !ring_push(ev.proc_id);
    end
    if (do_disp) begin
      if (ring_cnt != 0) begin
        cpu_id = ring_mem[ring_rd];
        p = prio_tab[cpu_id];
        q = (p == PRIO_HIGH) ? q_high : (p == PRIO_MID) ? q_mid : q_low;
        ring_rd++;
        ring_cnt--;
        cpu_valid = 1'b1;
        cpu_deadline = ev.now + TIME_W'(q);
        r.dispatched = 1'b1;
      end else begin
        cpu_id = '0;
        cpu_valid = 1'b0;
        cpu_deadline = '0;
      end
    end
    r.cpu_busy = cpu_valid;
    r.running_id = cpu_valid ? cpu_id : '0;
    r.slice_end = cpu_valid ? cpu_deadline : '0;
    return r;
  endfunction

  // called at a falling edge, returns at a falling edge
  task automatic send_event(input logic [CMD_W-1:0] cmd, input logic [PID_W-1:0] pid,
                            input logic [PRIO_W-1:0] prio, input logic [TIME_W-1:0] t);
    sched_event_t ev;
    ev = '{cmd: cmd, proc_id: pid, proc_priority: prio, now: t};
    in_ch.valid = 1'b1;
    in_ch.cmd = cmd;
    in_ch.proc_id = pid;
    in_ch.proc_priority = prio;
    in_ch.now = t;
    do @(posedge clk); while (!in_ch.ready);
    expected_q.push_back(predict_dispatch(ev));
    @(negedge clk);
    if (tx_gaps_on && $urandom_range(0, 3) == 0) begin
      in_ch.valid = 1'b0;
      repeat (gap_cycles()) @(negedge clk);
    end
  endtask

  task automatic write_quantum(input logic [1:0] idx, input logic [QUANT_W-1:0] value);
    logic [CFG_DATA_W-1:0] rd;
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = CFG_ADDR_W'({idx, 2'b00});
    pwdata = $urandom();
    pwdata[QUANT_W-1:0] = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_Q_HIGH: q_high = value;
      REG_Q_MID:  q_mid = value;
      REG_Q_LOW:  q_low = value;
      default: ;
    endcase
    @(negedge clk);
    pwrite = 1'b0;
    penable = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    rd = prdata;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    if (rd[QUANT_W-1:0] !== value) begin
      $error("prdata reg %0d exp %0h got %0h", idx, value, rd[QUANT_W-1:0]);
      errors++;
    end
  endtask

  task automatic set_quanta(input logic [QUANT_W-1:0] hi, input logic [QUANT_W-1:0] mid,
                            input logic [QUANT_W-1:0] lo);
    write_quantum(REG_Q_HIGH, hi);
    write_quantum(REG_Q_MID, mid);
    write_quantum(REG_Q_LOW, lo);
  endtask

  // wait for all outstanding results plus pipeline slack
  task automatic settle();
    int n;
    in_ch.valid = 1'b0;
    n = 0;
    while (expected_q.size() != 0 && n < 100000) begin
      @(negedge clk);
      n++;
    end
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (expected_q.size() != 0) begin
      $error("%0d results never arrived", expected_q.size());
      errors++;
      expected_q.delete();
    end
  endtask

  task automatic test_basic_dispatch();
    tx_gaps_on = 1'b1;
    rx_stalls_on = 1'b1;
    send_event(CMD_LEAVE, 7'd0, PRIO_HIGH, 32'd0);           // empty queue, stays idle
    send_event(CMD_READY, 7'd127, PRIO_HIGH, 32'd0);
    send_event(CMD_READY, 7'd5, PRIO_MID, 32'd100);          // busy: queued only
    send_event(CMD_READY, 7'd6, PRIO_LOW, 32'd200);
    send_event(CMD_READY, 7'd7, PRIO_SPARE, 32'd300);
    send_event(CMD_PREEMPT, 7'd127, PRIO_LOW, 32'd400);
    send_event(CMD_LEAVE_ALT, 7'd5, PRIO_HIGH, 32'd500);
    send_event(CMD_LEAVE, 7'd6, PRIO_HIGH, 32'hFFFF_FFFF);   // slice add wraps
    send_event(CMD_LEAVE, 7'd7, PRIO_SPARE, 32'h8000_0000);
    send_event(CMD_LEAVE, 7'd127, PRIO_HIGH, 32'd600);
    send_event(CMD_PREEMPT, 7'd127, PRIO_MID, 32'd700);      // requeue on idle cpu
    send_event(CMD_LEAVE, 7'd127, PRIO_HIGH, 32'd800);
    settle();
  endtask

  task automatic test_quantum_extremes();
    set_quanta(16'hFFFF, 16'd0, 16'd1);
    send_event(CMD_READY, 7'd1, PRIO_HIGH, 32'hFFFF_FFF0);
    send_event(CMD_READY, 7'd2, PRIO_MID, 32'd10);
    send_event(CMD_READY, 7'd3, PRIO_LOW, 32'd20);
    send_event(CMD_PREEMPT, 7'd1, PRIO_HIGH, 32'd30);        // zero slice
    send_event(CMD_LEAVE, 7'd2, PRIO_HIGH, 32'd40);
    send_event(CMD_LEAVE_ALT, 7'd3, PRIO_HIGH, 32'hFFFF_0001);
    send_event(CMD_LEAVE, 7'd1, PRIO_HIGH, 32'd50);
    send_event(CMD_READY, 7'd0, PRIO_SPARE, 32'd0);
    send_event(CMD_LEAVE, 7'd0, PRIO_HIGH, 32'd60);
    settle();
  endtask

  task automatic test_queue_full();
    set_quanta(16'd10, 16'd5, 16'd2);
    sim_now = '0;
    // ready events on a busy cpu fill the ring
    while (ring_cnt < MAX_PROCS) begin
      sim_now += $urandom_range(0, 9);
      send_event(CMD_READY, PID_W'($urandom()), PRIO_W'($urandom_range(0, 3)), sim_now);
    end
    repeat (3) send_event(CMD_READY, PID_W'($urandom()), PRIO_LOW, sim_now);
    send_event(CMD_PREEMPT, cpu_id, PRIO_HIGH, sim_now + 1);  // dropped, still dispatches
    send_event(CMD_PREEMPT, cpu_id, PRIO_HIGH, sim_now + 2);
    while (cpu_valid) begin
      sim_now += $urandom_range(0, 9);
      send_event(CMD_LEAVE, cpu_id, PRIO_W'($urandom()), sim_now);
    end
    settle();
  endtask

  task automatic test_random_traffic(input int n_items);
    int                sel;
    int                ready_pct;
    int                start;
    logic              found;
    logic [PID_W-1:0]  pid;
    logic [TIME_W-1:0] t;
    for (int i = 0; i < n_items; i++) begin
      sel = $urandom_range(0, 99);
      ready_pct = (ring_cnt > 16) ? 25 : 50;
      case ($urandom_range(0, 19))
        0, 1:    t = $urandom();
        2:       t = 32'hFFFF_FFFF - $urandom_range(0, 70000);
        default: begin
          sim_now += $urandom_range(0, 40);
          t = sim_now;
        end
      endcase
      if (sel < ready_pct) begin
        send_event(CMD_READY, PID_W'($urandom()), PRIO_W'($urandom_range(0, 3)), t);
      end else if (sel < ready_pct + 25) begin
        found = 1'b0;
        pid = '0;
        if (cpu_valid && $urandom_range(0, 7) != 0) begin
          pid = cpu_id;
          found = 1'b1;
        end else begin
          // only ids with a stored priority may be queued by preempt
          start = $urandom_range(0, MAX_PROCS - 1);
          for (int k = 0; k < MAX_PROCS && !found; k++) begin
            if (prio_known[(start + k) % MAX_PROCS]) begin
              pid = PID_W'((start + k) % MAX_PROCS);
              found = 1'b1;
            end
          end
        end
        if (found) send_event(CMD_PREEMPT, pid, PRIO_W'($urandom()), t);
        else send_event(CMD_READY, PID_W'($urandom()), PRIO_W'($urandom()), t);
      end else begin
        pid = (cpu_valid && $urandom_range(0, 3) != 0) ? cpu_id : PID_W'($urandom());
        send_event(($urandom_range(0, 7) == 0) ? CMD_LEAVE_ALT : CMD_LEAVE, pid,
                   PRIO_W'($urandom()), t);
      end
    end
    settle();
  endtask

  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_ch.ready = 1'b0;
      stall_left--;
    end else begin
      out_ch.ready = 1'b1;
      if (rx_stalls_on && $urandom_range(0, 3) == 0) stall_left = gap_cycles();
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_q.size() == 0) begin
        $error("result item with nothing expected");
        errors++;
      end else begin
        want_res = expected_q.pop_front();
        if (out_ch.dispatched !== want_res.dispatched) begin
          $error("dispatched exp %0h got %0h", want_res.dispatched, out_ch.dispatched);
          errors++;
        end
        if (out_ch.cpu_busy !== want_res.cpu_busy) begin
          $error("cpu_busy exp %0h got %0h", want_res.cpu_busy, out_ch.cpu_busy);
          errors++;
        end
        if (out_ch.running_id !== want_res.running_id) begin
          $error("running_id exp %0h got %0h", want_res.running_id, out_ch.running_id);
          errors++;
        end
        if (out_ch.slice_end !== want_res.slice_end) begin
          $error("slice_end exp %0h got %0h", want_res.slice_end, out_ch.slice_end);
          errors++;
        end
        if (out_ch.enqueue_dropped !== want_res.enqueue_dropped) begin
          $error("enqueue_dropped exp %0h got %0h", want_res.enqueue_dropped,
                 out_ch.enqueue_dropped);
          errors++;
        end
      end
    end
  end

  initial begin
    #10_000_000;
    $display("** fifo_dispatcher_with_priority_quantum: FAILED **");
    $finish;
  end

  initial begin
    errors = 0;
    stall_left = 0;
    tx_gaps_on = 1'b0;
    rx_stalls_on = 1'b0;
    rst_n = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_ch.valid = 1'b0;
    in_ch.cmd = CMD_READY;
    in_ch.proc_id = '0;
    in_ch.proc_priority = PRIO_HIGH;
    in_ch.now = '0;
    out_ch.ready = 1'b0;
    ring_rd = '0;
    ring_wr = '0;
    ring_cnt = '0;
    cpu_id = '0;
    cpu_valid = 1'b0;
    cpu_deadline = '0;
    q_high = Q_HIGH_RST;
    q_mid = Q_MID_RST;
    q_low = Q_LOW_RST;
    sim_now = '0;
    for (int i = 0; i < MAX_PROCS; i++) begin
      prio_known[i] = 1'b0;
      prio_tab[i] = PRIO_HIGH;
      ring_mem[i] = '0;
    end
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_basic_dispatch();
    test_quantum_extremes();
    test_queue_full();

    tx_gaps_on = 1'b0;
    rx_stalls_on = 1'b0;
    set_quanta(16'd10, 16'd5, 16'd2);
    test_random_traffic(270);

    tx_gaps_on = 1'b1;
    rx_stalls_on = 1'b1;
    set_quanta(QUANT_W'($urandom()), QUANT_W'($urandom()), QUANT_W'($urandom()));
    test_random_traffic(270);

    set_quanta(16'hFFFF, 16'd1, 16'hFFFF);
    test_random_traffic(270);

    rx_stalls_on = 1'b0;
    set_quanta(QUANT_W'($urandom_range(1, 65535)), QUANT_W'($urandom_range(1, 300)),
               QUANT_W'($urandom_range(1, 65535)));
    test_random_traffic(270);

    settle();
    if (errors == 0) begin
      $display("** fifo_dispatcher_with_priority_quantum: PASSED **");
    end else begin
      $display("** fifo_dispatcher_with_priority_quantum: FAILED **");
    end
    $finish;
  end

endmodule

// ----- files.f -----
design/fdpq_pkg.sv
design/fdpq_ifs.sv
design/fdpq_ring.sv
design/fifo_dispatcher_with_priority_quantum.sv
sim/tb_fifo_dispatcher_with_priority_quantum.sv
